>>> hdl/answer_countdown_timer_display_top_defines.svh
// Assertion macros used by the timer core (acdt_core)
`ifndef ANSWER_COUNTDOWN_TIMER_DISPLAY_TOP_DEFINES_SVH
`define ANSWER_COUNTDOWN_TIMER_DISPLAY_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, switched off while reset is high
`define ACDT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("acdt assertion failed");
// Checked property, also active during reset
`define ACDT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("acdt assertion failed");
`else
`define ACDT_ASSERT(label, clk, rst, prop)
`define ACDT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> hdl/acdt_pkg.sv
package acdt_pkg;

  // Item field types
  typedef logic [1:0] cmd_t;
  typedef logic [3:0] buttons_t;
  typedef logic [7:0] seg_t;
  typedef logic [1:0] phase_t;
  typedef logic [2:0] answer_t;
  typedef logic [3:0] digit_t;

  // Configuration port
  typedef logic [1:0] cfg_index_t;
  typedef logic [7:0] cfg_data_t;

  localparam cfg_index_t REG_TICKS_PER_TENTH   = 2'd0;
  localparam cfg_index_t REG_SHOW_CYCLE_LENGTH = 2'd1;
  localparam cfg_index_t REG_START_SECONDS     = 2'd2;

  localparam logic [7:0] TICKS_PER_TENTH_RST   = 8'd10;
  localparam logic [7:0] SHOW_CYCLE_LENGTH_RST = 8'd20;
  localparam digit_t     START_SECONDS_RST     = 4'd5;

  // Commands
  localparam cmd_t CMD_TICK   = 2'd0;
  localparam cmd_t CMD_START  = 2'd1;
  localparam cmd_t CMD_ANSWER = 2'd2;

  // Phase codes
  localparam phase_t PHASE_FROZEN   = 2'd0;
  localparam phase_t PHASE_COUNTING = 2'd1;
  localparam phase_t PHASE_SHOWING  = 2'd2;

  // Answer codes
  localparam answer_t ANS_NONE = 3'd0;
  localparam answer_t ANS_A    = 3'd1;
  localparam answer_t ANS_B    = 3'd2;
  localparam answer_t ANS_C    = 3'd3;
  localparam answer_t ANS_D    = 3'd4;

  localparam seg_t SEG_BLANK      = 8'hFF;
  localparam seg_t SEG_DASH_POINT = 8'h3F;
  localparam digit_t DIGIT_LIMIT  = 4'd10;

  // One result item
  typedef struct packed {
    seg_t    left_segments;
    seg_t    right_segments;
    phase_t  phase;
    answer_t answer_code;
  } result_t;

  // Seconds digit with decimal point, active low
  function automatic seg_t left_digit_seg(digit_t d);
    case (d)
      4'd0:    left_digit_seg = 8'h40;
      4'd1:    left_digit_seg = 8'h79;
      4'd2:    left_digit_seg = 8'h24;
      4'd3:    left_digit_seg = 8'h30;
      4'd4:    left_digit_seg = 8'h19;
      4'd5:    left_digit_seg = 8'h12;
      4'd6:    left_digit_seg = 8'h02;
      4'd7:    left_digit_seg = 8'h78;
      4'd8:    left_digit_seg = 8'h00;
      4'd9:    left_digit_seg = 8'h10;
      default: left_digit_seg = SEG_BLANK;
    endcase
  endfunction

  // Tenths digit without point, active low
  function automatic seg_t right_digit_seg(digit_t d);
    case (d)
      4'd0:    right_digit_seg = 8'hC0;
      4'd1:    right_digit_seg = 8'hF9;
      4'd2:    right_digit_seg = 8'hA4;
      4'd3:    right_digit_seg = 8'hB0;
      4'd4:    right_digit_seg = 8'h99;
      4'd5:    right_digit_seg = 8'h92;
      4'd6:    right_digit_seg = 8'h82;
      4'd7:    right_digit_seg = 8'hF8;
      4'd8:    right_digit_seg = 8'h80;
      4'd9:    right_digit_seg = 8'h90;
      default: right_digit_seg = SEG_BLANK;
    endcase
  endfunction

  // Answer letter, dash for no answer
  function automatic seg_t letter_seg(answer_t a);
    case (a)
      ANS_NONE: letter_seg = 8'hBF;
      ANS_A:    letter_seg = 8'h88;
      ANS_B:    letter_seg = 8'h83;
      ANS_C:    letter_seg = 8'hC6;
      ANS_D:    letter_seg = 8'hA1;
      default:  letter_seg = SEG_BLANK;
    endcase
  endfunction

endpackage

>>> hdl/acdt_in_if.sv
interface acdt_in_if;
  import acdt_pkg::*;

  logic     valid;
  logic     ready;
  cmd_t     command;
  buttons_t answer_buttons;

  modport source (output valid, output command, output answer_buttons, input ready);
  modport sink   (input valid, input command, input answer_buttons, output ready);
endinterface

>>> hdl/acdt_out_if.sv
interface acdt_out_if;
  import acdt_pkg::*;

  logic    valid;
  logic    ready;
  seg_t    left_segments;
  seg_t    right_segments;
  phase_t  phase;
  answer_t answer_code;

  modport source (output valid, output left_segments, output right_segments,
                  output phase, output answer_code, input ready);
  modport sink   (input valid, input left_segments, input right_segments,
                  input phase, input answer_code, output ready);
endinterface

>>> hdl/acdt_core.sv
`include "answer_countdown_timer_display_top_defines.svh"

module acdt_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  acdt_pkg::cmd_t       command,
  input  acdt_pkg::buttons_t   answer_buttons,
  input  logic                 cfg_we,
  input  acdt_pkg::cfg_index_t cfg_index,
  input  acdt_pkg::cfg_data_t  cfg_data,
  output acdt_pkg::result_t    result_next
);
  import acdt_pkg::*;

  // Configuration registers
  logic [7:0] ticks_per_tenth;
  logic [7:0] show_cycle_length;
  digit_t     start_seconds;

  // Timer state
  logic [7:0] prescale_count, prescale_count_next;
  digit_t     seconds_left, seconds_left_next;
  digit_t     tenths_left, tenths_left_next;
  logic       frozen_flag, frozen_flag_next;
  logic       waiting_flag, waiting_flag_next;
  digit_t     latched_seconds, latched_seconds_next;
  digit_t     latched_tenths, latched_tenths_next;
  logic [7:0] show_count, show_count_next;
  answer_t    latched_answer, latched_answer_next;
  seg_t       left_display, left_display_next;
  seg_t       right_display, right_display_next;

  // Display request from the step logic
  logic       show_time_en;
  logic       show_answer_en;
  digit_t     time_secs;
  digit_t     time_tenths;
  logic [7:0] show_dec;

  // Events watched by the checks
  logic       tick_hold;
  logic       answer_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_tenth   <= TICKS_PER_TENTH_RST;
      show_cycle_length <= SHOW_CYCLE_LENGTH_RST;
      start_seconds     <= START_SECONDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICKS_PER_TENTH:   ticks_per_tenth   <= cfg_data;
        REG_SHOW_CYCLE_LENGTH: show_cycle_length <= cfg_data;
        REG_START_SECONDS:     start_seconds     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Next state for one accepted item
  always_comb begin
    prescale_count_next  = prescale_count;
    seconds_left_next    = seconds_left;
    tenths_left_next     = tenths_left;
    frozen_flag_next     = frozen_flag;
    waiting_flag_next    = waiting_flag;
    latched_seconds_next = latched_seconds;
    latched_tenths_next  = latched_tenths;
    show_count_next      = show_count;
    latched_answer_next  = latched_answer;
    show_time_en         = 1'b0;
    show_answer_en       = 1'b0;
    time_secs            = seconds_left;
    time_tenths          = tenths_left;
    show_dec             = show_count - 8'd1;

    if (fire) begin
      case (command)
        CMD_TICK: begin
          if (prescale_count > 8'd1) begin
            prescale_count_next = prescale_count - 8'd1;
          end else begin
            prescale_count_next = ticks_per_tenth;
            if (waiting_flag) begin
              // countdown step
              if (tenths_left == 4'd0) begin
                if (seconds_left == 4'd0) begin
                  waiting_flag_next    = 1'b0;
                  latched_answer_next  = ANS_NONE;
                  latched_seconds_next = 4'd0;
                  latched_tenths_next  = 4'd0;
                end else begin
                  seconds_left_next = seconds_left - 4'd1;
                  tenths_left_next  = 4'd9;
                end
              end else begin
                tenths_left_next = tenths_left - 4'd1;
              end
              show_time_en = 1'b1;
              time_secs    = seconds_left_next;
              time_tenths  = tenths_left_next;
            end else if (frozen_flag) begin
              show_time_en = 1'b1;
              time_secs    = start_seconds;
              time_tenths  = 4'd0;
            end else begin
              // alternate time and answer
              show_count_next = show_dec;
              if (show_dec >= {1'b0, show_cycle_length[7:1]}) begin
                show_time_en = 1'b1;
                time_secs    = latched_seconds;
                time_tenths  = latched_tenths;
              end else begin
                if (show_dec == 8'd0) begin
                  show_count_next = show_cycle_length;
                end
                show_answer_en = 1'b1;
              end
            end
          end
        end
        CMD_START: begin
          prescale_count_next = ticks_per_tenth;
          seconds_left_next   = start_seconds;
          tenths_left_next    = 4'd0;
          if (waiting_flag) begin
            show_time_en      = 1'b1;
            time_secs         = start_seconds;
            time_tenths       = 4'd0;
            frozen_flag_next  = 1'b1;
            waiting_flag_next = 1'b0;
          end else if (frozen_flag) begin
            waiting_flag_next = 1'b1;
            frozen_flag_next  = 1'b0;
          end else begin
            frozen_flag_next = 1'b1;
          end
        end
        CMD_ANSWER: begin
          if (waiting_flag) begin
            waiting_flag_next    = 1'b0;
            latched_seconds_next = seconds_left;
            latched_tenths_next  = tenths_left;
            show_count_next      = show_cycle_length;
            // lowest letter wins
            if (answer_buttons[0])      latched_answer_next = ANS_A;
            else if (answer_buttons[1]) latched_answer_next = ANS_B;
            else if (answer_buttons[2]) latched_answer_next = ANS_C;
            else if (answer_buttons[3]) latched_answer_next = ANS_D;
            else                        latched_answer_next = ANS_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Display bytes
  always_comb begin
    left_display_next  = left_display;
    right_display_next = right_display;
    if (show_time_en) begin
      if (time_secs < DIGIT_LIMIT) left_display_next = left_digit_seg(time_secs);
      if (time_tenths < DIGIT_LIMIT) right_display_next = right_digit_seg(time_tenths);
    end else if (show_answer_en) begin
      left_display_next = SEG_DASH_POINT;
      if (latched_answer <= ANS_D) right_display_next = letter_seg(latched_answer);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count  <= TICKS_PER_TENTH_RST;
      seconds_left    <= START_SECONDS_RST;
      tenths_left     <= 4'd0;
      frozen_flag     <= 1'b1;
      waiting_flag    <= 1'b0;
      latched_seconds <= START_SECONDS_RST;
      latched_tenths  <= 4'd0;
      show_count      <= SHOW_CYCLE_LENGTH_RST;
      latched_answer  <= ANS_NONE;
      left_display    <= SEG_BLANK;
      right_display   <= SEG_BLANK;
    end else begin
      prescale_count  <= prescale_count_next;
      seconds_left    <= seconds_left_next;
      tenths_left     <= tenths_left_next;
      frozen_flag     <= frozen_flag_next;
      waiting_flag    <= waiting_flag_next;
      latched_seconds <= latched_seconds_next;
      latched_tenths  <= latched_tenths_next;
      show_count      <= show_count_next;
      latched_answer  <= latched_answer_next;
      left_display    <= left_display_next;
      right_display   <= right_display_next;
    end
  end

  // Result as seen after this item
  always_comb begin
    result_next.left_segments  = left_display_next;
    result_next.right_segments = right_display_next;
    if (waiting_flag_next)     result_next.phase = PHASE_COUNTING;
    else if (frozen_flag_next) result_next.phase = PHASE_FROZEN;
    else                       result_next.phase = PHASE_SHOWING;
    result_next.answer_code = latched_answer_next;
  end

  assign tick_hold    = fire && command == CMD_TICK && prescale_count > 8'd1;
  assign answer_taken = fire && command == CMD_ANSWER && waiting_flag;

  // Checks
  `ACDT_ASSERT_ALWAYS(a_flags_exclusive, clk, rst || !(frozen_flag && waiting_flag))
  `ACDT_ASSERT_ALWAYS(a_tenths_digit, clk, rst || (tenths_left < DIGIT_LIMIT))
  `ACDT_ASSERT(a_answer_code, clk, rst, latched_answer <= ANS_D)
  `ACDT_ASSERT(a_prescale_hold, clk, rst, tick_hold |=> ($stable(left_display) && $stable(right_display)))
  `ACDT_ASSERT(a_answer_ends_count, clk, rst, answer_taken |=> (!waiting_flag && !frozen_flag))

endmodule

>>> hdl/acdt_out_buf.sv
module acdt_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  acdt_pkg::result_t result_next,
  output logic              can_load,
  acdt_out_if.source        out
);
  import acdt_pkg::*;

  logic    valid;
  result_t result;

  // Room when empty or when the held item leaves this cycle
  assign can_load = !valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

  assign out.valid          = valid;
  assign out.left_segments  = result.left_segments;
  assign out.right_segments = result.right_segments;
  assign out.phase          = result.phase;
  assign out.answer_code    = result.answer_code;

endmodule

>>> hdl/answer_countdown_timer_display_top.sv
// Answer countdown timer with two seven-segment display bytes.
// An accepted item's result is registered and presented on the output in the cycle after.
// Throughput: one item per cycle while the output takes its items; the output register frees as its item is taken.
// Every item yields exactly one result item.
// Reset (synchronous, active high): registers back to defaults, frozen at 5.0,
// displays blank (0xFF), output empty.
module answer_countdown_timer_display_top (
  input  logic                 clk,
  input  logic                 rst,
  acdt_in_if.sink              in,
  acdt_out_if.source           out,
  input  logic                 cfg_we,
  input  acdt_pkg::cfg_index_t cfg_index,
  input  acdt_pkg::cfg_data_t  cfg_data
);
  import acdt_pkg::*;

  logic    fire;
  logic    can_load;
  result_t result_next;

  assign in.ready = can_load;
  assign fire     = in.valid && can_load;

  acdt_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .command        (in.command),
    .answer_buttons (in.answer_buttons),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result_next    (result_next)
  );

  acdt_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .result_next (result_next),
    .can_load    (can_load),
    .out         (out)
  );

endmodule

>>> tb/answer_countdown_timer_display_top_test.sv
module answer_countdown_timer_display_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import acdt_pkg::*;

  // Command 3 has no meaning in the block and must leave everything alone
  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ROUNDS = 8;
  localparam int ROUND_ITEMS = 240;

  // Active-low glyphs: seconds with point, tenths, then the answer letters
  localparam logic [0:9][7:0] SECS_GLYPH =
    {8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78, 8'h00, 8'h10};
  localparam logic [0:9][7:0] TENTHS_GLYPH =
    {8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
  localparam logic [0:4][7:0] LETTER_GLYPH = {8'hBF, 8'h88, 8'h83, 8'hC6, 8'hA1};

  typedef struct packed {
    bit        set_regs;
    cfg_data_t ticks;
    cfg_data_t show;
    digit_t    start;
    cmd_t      cmd;
    buttons_t  buttons;
    bit        typed;
    result_t   want;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  acdt_in_if  in_ch ();
  acdt_out_if out_ch ();

  answer_countdown_timer_display_top dut (
    .clk       (clk),
    .rst       (rst),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timer copy: registers
  cfg_data_t cfg_ticks;
  cfg_data_t cfg_show;
  digit_t    cfg_start;
  // Timer copy: state
  logic [7:0] tick_div;
  digit_t     secs_left;
  digit_t     tenths_left;
  bit         frozen;
  bit         counting;
  digit_t     held_secs;
  digit_t     held_tenths;
  logic [7:0] show_ctr;
  answer_t    held_answer;
  seg_t       disp_left;
  seg_t       disp_right;

  result_t     due_readouts [$];
  script_row_t directed_rows [$];
  int          fault_count = 0;
  int          cycles = 0;
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;

  function automatic void show_digits(digit_t s, digit_t t);
    if (s < DIGIT_LIMIT) disp_left = SECS_GLYPH[s];
    if (t < DIGIT_LIMIT) disp_right = TENTHS_GLYPH[t];
  endfunction

  // One tenth-second step, depending on the phase
  function automatic void advance_tenth();
    if (counting) begin
      if (tenths_left == 4'd0) begin
        if (secs_left == 4'd0) begin
          // ran out: nothing answered, no time left
          counting = 1'b0;
          held_answer = ANS_NONE;
          held_secs = 4'd0;
          held_tenths = 4'd0;
        end else begin
          secs_left = secs_left - 4'd1;
          tenths_left = 4'd9;
        end
      end else begin
        tenths_left = tenths_left - 4'd1;
      end
      show_digits(secs_left, tenths_left);
    end else if (frozen) begin
      show_digits(cfg_start, 4'd0);
    end else begin
      // first half of the cycle shows the time, second half the letter
      show_ctr = show_ctr - 8'd1;
      if (show_ctr >= (cfg_show >> 1)) begin
        show_digits(held_secs, held_tenths);
      end else begin
        if (show_ctr == 8'd0) show_ctr = cfg_show;
        disp_left = SEG_DASH_POINT;
        disp_right = LETTER_GLYPH[held_answer];
      end
    end
  endfunction

  function automatic result_t timer_step(cmd_t c, buttons_t b);
    result_t r;
    case (c)
      CMD_TICK: begin
        if (tick_div > 8'd1) begin
          tick_div = tick_div - 8'd1;
        end else begin
          tick_div = cfg_ticks;
          advance_tenth();
        end
      end
      CMD_START: begin
        tick_div = cfg_ticks;
        secs_left = cfg_start;
        tenths_left = 4'd0;
        if (counting) begin
          show_digits(secs_left, tenths_left);
          frozen = 1'b1;
          counting = 1'b0;
        end else if (frozen) begin
          counting = 1'b1;
          frozen = 1'b0;
        end else begin
          // leaving the result display does not touch the digits
          frozen = 1'b1;
        end
      end
      CMD_ANSWER: begin
        if (counting) begin
          counting = 1'b0;
          held_secs = secs_left;
          held_tenths = tenths_left;
          show_ctr = cfg_show;
          // lowest letter wins
          if (b[0])      held_answer = ANS_A;
          else if (b[1]) held_answer = ANS_B;
          else if (b[2]) held_answer = ANS_C;
          else if (b[3]) held_answer = ANS_D;
          else           held_answer = ANS_NONE;
        end
      end
      default: ;
    endcase
    r.left_segments = disp_left;
    r.right_segments = disp_right;
    r.phase = counting ? PHASE_COUNTING : (frozen ? PHASE_FROZEN : PHASE_SHOWING);
    r.answer_code = held_answer;
    return r;
  endfunction

  function automatic void add_item(cmd_t c, buttons_t b, bit typed = 1'b0,
                                   result_t want = '0);
    script_row_t row;
    row = '0;
    row.cmd = c;
    row.buttons = b;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_regs(cfg_data_t ticks, cfg_data_t show, digit_t start);
    script_row_t row;
    row = '0;
    row.set_regs = 1'b1;
    row.ticks = ticks;
    row.show = show;
    row.start = start;
    directed_rows.push_back(row);
  endfunction

  // Send one item; valid stays high after acceptance unless a gap follows
  task automatic send_event(cmd_t c, buttons_t b, bit typed, result_t fixed);
    int      gap;
    result_t want;
    if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
    gap = calm_tx ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c;
    in_ch.answer_buttons <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = timer_step(c, b);
    due_readouts.push_back(typed ? fixed : want);
  endtask

  // Registers change only once every result is back
  task automatic load_regs(cfg_data_t ticks, cfg_data_t show, digit_t start);
    in_ch.valid <= 1'b0;
    while (due_readouts.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_TICKS_PER_TENTH;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_index <= REG_SHOW_CYCLE_LENGTH;
    cfg_data <= show;
    @(posedge clk);
    cfg_index <= REG_START_SECONDS;
    cfg_data <= cfg_data_t'(start);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_ticks = ticks;
    cfg_show = show;
    cfg_start = start;
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, then compare with the oldest expectation
  initial begin : result_sink
    int      stall;
    result_t got;
    result_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_rx = !calm_rx;
      stall = calm_rx ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.left_segments = out_ch.left_segments;
      got.right_segments = out_ch.right_segments;
      got.phase = out_ch.phase;
      got.answer_code = out_ch.answer_code;
      if (due_readouts.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result: left %h right %h phase %0d answer %0d",
                   got.left_segments, got.right_segments, got.phase, got.answer_code);
      end else begin
        want = due_readouts.pop_front();
        if (got.left_segments !== want.left_segments ||
            got.right_segments !== want.right_segments ||
            got.phase !== want.phase || got.answer_code !== want.answer_code) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: left %h/%h right %h/%h phase %0d/%0d answer %0d/%0d",
                     want.left_segments, got.left_segments,
                     want.right_segments, got.right_segments,
                     want.phase, got.phase, want.answer_code, got.answer_code);
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    script_row_t row;
    buttons_t    b;
    cmd_t        c;
    int          useful;
    int          pick;
    int          start_pct;
    int          answer_pct;
    bit          ignored;

    cfg_ticks = TICKS_PER_TENTH_RST;
    cfg_show = SHOW_CYCLE_LENGTH_RST;
    cfg_start = START_SECONDS_RST;
    tick_div = TICKS_PER_TENTH_RST;
    secs_left = START_SECONDS_RST;
    tenths_left = 4'd0;
    frozen = 1'b1;
    counting = 1'b0;
    held_secs = START_SECONDS_RST;
    held_tenths = 4'd0;
    show_ctr = SHOW_CYCLE_LENGTH_RST;
    held_answer = ANS_NONE;
    disp_left = SEG_BLANK;
    disp_right = SEG_BLANK;

    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_TICK;
    in_ch.answer_buttons <= 4'h0;
    cfg_we <= 1'b0;
    cfg_index <= REG_TICKS_PER_TENTH;
    cfg_data <= '0;

    // Directed: blank after reset, unused command, answer while frozen,
    // start/stop, instant timeout, answer while showing, button priority
    add_item(CMD_TICK, 4'h0, 1'b1, '{SEG_BLANK, SEG_BLANK, PHASE_FROZEN, ANS_NONE});
    add_item(CMD_UNUSED, 4'hF, 1'b1, '{SEG_BLANK, SEG_BLANK, PHASE_FROZEN, ANS_NONE});
    add_item(CMD_ANSWER, 4'h1, 1'b1, '{SEG_BLANK, SEG_BLANK, PHASE_FROZEN, ANS_NONE});
    add_item(CMD_START, 4'h0, 1'b1, '{SEG_BLANK, SEG_BLANK, PHASE_COUNTING, ANS_NONE});
    add_item(CMD_START, 4'h0, 1'b1, '{8'h12, 8'hC0, PHASE_FROZEN, ANS_NONE});
    add_regs(8'd1, 8'd2, 4'd0);
    add_item(CMD_START, 4'h0);
    add_item(CMD_TICK, 4'h0);
    add_item(CMD_TICK, 4'h0);
    add_item(CMD_ANSWER, 4'hF);
    add_item(CMD_START, 4'h0);
    add_item(CMD_TICK, 4'h0);
    add_regs(8'd1, 8'd254, 4'd9);
    add_item(CMD_START, 4'h0);
    add_item(CMD_TICK, 4'h0);
    add_item(CMD_ANSWER, 4'h0);
    for (int i = 1; i < 5; i++) begin
      add_item(CMD_START, 4'h0);
      add_item(CMD_START, 4'h0);
      add_item(CMD_ANSWER, (i == 1) ? 4'hF : (i == 2) ? 4'h6 : (i == 3) ? 4'hC : 4'h8);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.set_regs) load_regs(row.ticks, row.show, row.start);
      else send_event(row.cmd, row.buttons, row.typed, row.want);
    end

    // Random rounds, each under its own register setting
    for (int round = 0; round < ROUNDS; round++) begin
      if (round == 0) begin
        load_regs(8'd255, 8'd254, 4'd9);
      end else if (round == 1) begin
        load_regs(8'd1, 8'd2, 4'd0);
      end else begin
        load_regs(cfg_data_t'($urandom_range(1, 3)),
                  ($urandom_range(0, 3) == 0) ? cfg_data_t'($urandom_range(2, 254))
                                              : cfg_data_t'($urandom_range(2, 10)),
                  digit_t'($urandom_range(0, 9)));
      end
      start_pct = $urandom_range(2, 8);
      answer_pct = $urandom_range(1, 12);
      useful = 0;
      while (useful < ROUND_ITEMS) begin
        pick = $urandom_range(0, 99);
        b = buttons_t'($urandom_range(0, 15));
        if (pick < 1) c = CMD_UNUSED;
        else if (pick < 1 + start_pct) c = CMD_START;
        else if (pick < 1 + start_pct + answer_pct) c = CMD_ANSWER;
        else c = CMD_TICK;
        // answers outside the countdown and the unused command change nothing
        ignored = (c == CMD_UNUSED) || (c == CMD_ANSWER && !counting);
        send_event(c, b, 1'b0, '0);
        if (!ignored) useful++;
      end
    end

    in_ch.valid <= 1'b0;
    while (due_readouts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
